// File: design/assert_macros.svh
// Assertion macros used by the port-level checker file.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: design/cgpp_pkg.sv
// Shared types and constants of the camera goal packet polar block.
// Depends on nothing.
package cgpp_pkg;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgStartOne = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartTwo = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAttackBlue = 2'd2;
  localparam logic [7:0] AbsentByte = 8'd255;
  localparam logic [7:0] CentreOffset = 8'd60;
  localparam int unsigned CoordW = 28;
  localparam int unsigned AngW = 25;
  localparam logic signed [AngW-1:0] QuarterQ16 = 25'sd5898240;
  localparam logic [31:0] GainInv = 32'd2608131496;
  localparam int AngleMin = -1440;
  localparam int AngleMax = 4320;
  localparam int unsigned DistMax = 5771;

  typedef struct packed {
    logic [7:0] yx;
    logic [7:0] yy;
    logic [7:0] bx;
    logic [7:0] by;
    logic       blue;
  } frame_t;

  function automatic logic signed [AngW-1:0] atan_q16(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0: r = 25'sd2949120;  5'd1: r = 25'sd1740967; 5'd2: r = 25'sd919879;
      5'd3: r = 25'sd466945;   5'd4: r = 25'sd234379;  5'd5: r = 25'sd117304;
      5'd6: r = 25'sd58666;    5'd7: r = 25'sd29335;   5'd8: r = 25'sd14668;
      5'd9: r = 25'sd7334;     5'd10: r = 25'sd3667;   5'd11: r = 25'sd1833;
      5'd12: r = 25'sd917;     5'd13: r = 25'sd458;    5'd14: r = 25'sd229;
      5'd15: r = 25'sd115;     5'd16: r = 25'sd57;     5'd17: r = 25'sd29;
      5'd18: r = 25'sd14;      5'd19: r = 25'sd7;      5'd20: r = 25'sd4;
      5'd21: r = 25'sd2;       5'd22: r = 25'sd1;      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// File: design/camera_goal_packet_polar.sv
// Top level of the camera goal packet polar block.
// Depends on cgpp_pkg, cgpp_framer, cgpp_fifo and cgpp_polar.
//
// Bytes enter through push/full, one per cycle while full is low. A two-byte
// header (start_byte_one, start_byte_two) opens a packet of four payload
// bytes; the last payload byte queues a frame for the polar unit.
// Results leave through empty/pop: the oldest result stays on the ports while
// empty is low and is taken when pop is high.
// The polar unit runs a shared CORDIC stage for each goal in turn and takes
// no new frame until it has moved the last result to the output register.
// A two-frame queue between framer and polar unit absorbs bursts; when pop
// is held low the result register, then the queue, then full back up.
// Reset clears header hunt, queue and result valid; config registers reset to zero.
// Configuration: write cfg_we_i with cfg_idx_i and cfg_data_i, taken at once.
module camera_goal_packet_polar #(
  parameter int unsigned CordicSteps = cgpp_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         link_byte_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [13:0] attack_angle_o,
  output logic [12:0]        attack_distance_o,
  output logic signed [13:0] defend_angle_o,
  output logic [12:0]        defend_distance_o,
  output logic               attack_seen_o,
  output logic               defend_seen_o
);
  logic [7:0] one_q, two_q;
  logic blue_q;
  logic fv, fr, qv, qr;
  cgpp_pkg::frame_t fd, qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q <= '0; two_q <= '0; blue_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cgpp_pkg::CfgStartOne: one_q <= cfg_data_i;
        cgpp_pkg::CfgStartTwo: two_q <= cfg_data_i;
        cgpp_pkg::CfgAttackBlue: blue_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cgpp_framer u_framer (
    .clk_i, .rst_ni, .push, .full, .link_byte_i,
    .start_one_i(one_q), .start_two_i(two_q), .attack_blue_i(blue_q),
    .frm_valid_o(fv), .frm_ready_i(fr), .frm_o(fd)
  );

  cgpp_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd)
  );

  cgpp_polar #(.CordicSteps(CordicSteps)) u_polar (
    .clk_i, .rst_ni, .in_valid_i(qv), .in_ready_o(qr), .in_i(qd),
    .empty, .pop, .attack_angle_o, .attack_distance_o, .defend_angle_o,
    .defend_distance_o, .attack_seen_o, .defend_seen_o
  );
endmodule

// File: design/cgpp_framer.sv
// Header hunt and payload capture; emits one frame per complete packet.
// Depends on cgpp_pkg.
module cgpp_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        link_byte_i,
  input  logic [7:0]        start_one_i,
  input  logic [7:0]        start_two_i,
  input  logic              attack_blue_i,
  output logic              frm_valid_o,
  input  logic              frm_ready_i,
  output cgpp_pkg::frame_t  frm_o
);
  logic [2:0] pos_q, pos_d;
  logic [7:0] st_q [3];
  logic       fv_q;
  logic       take;

  assign full = fv_q && !frm_ready_i;
  assign take = push && !full;
  assign frm_valid_o = fv_q;

  always_comb begin
    pos_d = pos_q;
    unique case (pos_q)
      3'd1: begin
        if (link_byte_i == start_two_i) pos_d = 3'd2;
        else if (link_byte_i == start_one_i) pos_d = 3'd1;
        else pos_d = 3'd0;
      end
      3'd2, 3'd3, 3'd4: pos_d = pos_q + 3'd1;
      3'd5: pos_d = 3'd0;
      default: pos_d = (link_byte_i == start_one_i) ? 3'd1 : 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
      fv_q  <= 1'b0;
    end else begin
      if (take && pos_q == 3'd5) fv_q <= 1'b1;
      else if (frm_ready_i) fv_q <= 1'b0;
      if (take) pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (pos_q >= 3'd2 && pos_q <= 3'd4) st_q[pos_q[1:0] - 2'd2] <= link_byte_i;
      if (pos_q == 3'd5) begin
        frm_o.yx   <= st_q[0];
        frm_o.yy   <= st_q[1];
        frm_o.bx   <= st_q[2];
        frm_o.by   <= link_byte_i;
        frm_o.blue <= attack_blue_i;
      end
    end
  end
endmodule

// File: design/cgpp_fifo.sv
// Two-entry frame queue between the framer and the polar unit.
// Depends on cgpp_pkg.
module cgpp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  cgpp_pkg::frame_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output cgpp_pkg::frame_t rd_data_o
);
  cgpp_pkg::frame_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// File: design/cgpp_polar.sv
// Iterative CORDIC vectoring for both goals, with output register.
// Depends on cgpp_pkg.
module cgpp_polar #(
  parameter int unsigned CordicSteps = cgpp_pkg::CordicStepsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cgpp_pkg::frame_t        in_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [13:0]      attack_angle_o,
  output logic [12:0]             attack_distance_o,
  output logic signed [13:0]      defend_angle_o,
  output logic [12:0]             defend_distance_o,
  output logic                    attack_seen_o,
  output logic                    defend_seen_o
);
  localparam int unsigned Steps =
    (CordicSteps > cgpp_pkg::AtanLen) ? cgpp_pkg::AtanLen : CordicSteps;
  localparam int unsigned CW = cgpp_pkg::CoordW;
  localparam int unsigned AW = cgpp_pkg::AngW;

  typedef enum logic [2:0] {StIdle, StLoad, StIter, StMul, StFin, StOut} st_e;
  st_e st_q;
  logic g_q;
  logic [4:0] i_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [AW-1:0] z_q;
  logic zero_q;
  cgpp_pkg::frame_t f_q;
  logic [63:0] prod_q;
  logic signed [13:0] ang_q [2];
  logic [12:0] dst_q [2];
  logic out_v_q;

  logic [7:0] rx, ry;
  logic signed [9:0] sx, sy;
  logic signed [CW-1:0] dx, dy;
  logic signed [AW+1:0] araw;
  logic signed [AW+1:0] ash;
  logic [31:0] xpos;
  logic [20:0] dsh;

  assign rx = g_q ? f_q.bx : f_q.yx;
  assign ry = g_q ? f_q.by : f_q.yy;
  always_comb begin
    sx = $signed({2'b00, rx});
    sy = $signed({2'b00, ry});
    if (rx != cgpp_pkg::AbsentByte) begin
      sx = sx - $signed({2'b00, cgpp_pkg::CentreOffset});
      sy = sy - $signed({2'b00, cgpp_pkg::CentreOffset});
    end
  end
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign xpos = x_q[CW-1] ? 32'd0 : {{(32-CW){1'b0}}, x_q};
  assign araw = $signed({{2{cgpp_pkg::QuarterQ16[AW-1]}}, cgpp_pkg::QuarterQ16})
              - $signed({{2{z_q[AW-1]}}, z_q}) + 27'sd2048;
  assign ash = araw >>> 12;
  assign dsh = prod_q[63:43] + 21'd1;

  assign in_ready_o = st_q == StIdle;
  assign empty = !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      if (pop && out_v_q && st_q != StOut) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (in_valid_i) begin f_q <= in_i; g_q <= 1'b0; st_q <= StLoad; end
        StLoad: begin
          zero_q <= (sx == 10'sd0) && (sy == 10'sd0);
          i_q <= 5'd0;
          if (sx < 0) begin
            if (sy >= 0) begin
              x_q <= CW'(sy) <<< 16; y_q <= -(CW'(sx) <<< 16); z_q <= cgpp_pkg::QuarterQ16;
            end else begin
              x_q <= -(CW'(sy) <<< 16); y_q <= CW'(sx) <<< 16; z_q <= -cgpp_pkg::QuarterQ16;
            end
          end else begin
            x_q <= CW'(sx) <<< 16; y_q <= CW'(sy) <<< 16; z_q <= '0;
          end
          st_q <= StIter;
        end
        StIter: begin
          if (y_q >= 0) begin
            x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + cgpp_pkg::atan_q16(i_q);
          end else begin
            x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - cgpp_pkg::atan_q16(i_q);
          end
          i_q <= i_q + 5'd1;
          if (i_q == 5'(Steps - 1)) st_q <= StMul;
        end
        StMul: begin
          prod_q <= xpos * cgpp_pkg::GainInv;
          st_q <= StFin;
        end
        StFin: begin
          if (zero_q) begin
            ang_q[g_q] <= 14'sd1440; dst_q[g_q] <= '0;
          end else begin
            if (ash < cgpp_pkg::AngleMin) ang_q[g_q] <= 14'(cgpp_pkg::AngleMin);
            else if (ash > cgpp_pkg::AngleMax) ang_q[g_q] <= 14'(cgpp_pkg::AngleMax);
            else ang_q[g_q] <= ash[13:0];
            if (dsh[20:1] > 20'(cgpp_pkg::DistMax)) dst_q[g_q] <= 13'(cgpp_pkg::DistMax);
            else dst_q[g_q] <= dsh[13:1];
          end
          if (g_q) st_q <= StOut;
          else begin g_q <= 1'b1; st_q <= StLoad; end
        end
        StOut: if (!out_v_q || pop) begin
          out_v_q <= 1'b1;
          st_q <= StIdle;
          attack_seen_o <= f_q.blue ? (f_q.by != cgpp_pkg::AbsentByte)
                                    : (f_q.yy != cgpp_pkg::AbsentByte);
          defend_seen_o <= f_q.blue ? (f_q.yy != cgpp_pkg::AbsentByte)
                                    : (f_q.by != cgpp_pkg::AbsentByte);
          attack_angle_o <= ang_q[f_q.blue];
          attack_distance_o <= dst_q[f_q.blue];
          defend_angle_o <= ang_q[!f_q.blue];
          defend_distance_o <= dst_q[!f_q.blue];
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// File: design/cgpp_checker.sv
// Port-level checks of the camera goal packet polar block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module cgpp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [13:0] attack_angle_o,
  input logic [12:0]        attack_distance_o
);
  `ASSERT_CLK(a_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(attack_angle_o), "result changed while stalled")
  `ASSERT_CLK(a_dist, clk_i, rst_ni, !empty |-> attack_distance_o <= 13'd5771, "distance out of range")
  `ASSERT_CLK(a_ang, clk_i, rst_ni, !empty |-> attack_angle_o >= -14'sd1440 && attack_angle_o <= 14'sd4320, "angle out of range")
  `ASSERT_RST(a_rst, clk_i, !rst_ni |=> empty, "result valid out of reset")
endmodule

bind camera_goal_packet_polar cgpp_checker u_cgpp_checker (
  .clk_i, .rst_ni, .empty, .pop, .attack_angle_o, .attack_distance_o
);

// File: verif/camera_goal_packet_polar_checker.sv
// Checker for camera_goal_packet_polar: watches the byte, register and result
// channels, predicts each goal report and compares it field by field.
// Depends on cgpp_pkg.
`timescale 1ns / 1ps
module camera_goal_packet_polar_checker #(
  parameter int unsigned CordicSteps = cgpp_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [7:0]         link_byte_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [13:0] attack_angle_i,
  input  logic [12:0]        attack_distance_i,
  input  logic signed [13:0] defend_angle_i,
  input  logic [12:0]        defend_distance_i,
  input  logic               attack_seen_i,
  input  logic               defend_seen_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 reports_o
);
  import cgpp_pkg::*;

  typedef struct {
    logic signed [13:0] a_ang;
    logic [12:0]        a_dist;
    logic signed [13:0] d_ang;
    logic [12:0]        d_dist;
    logic               a_seen;
    logic               d_seen;
  } goal_report_t;

  goal_report_t report_q[$];
  logic [7:0]   hdr_one, hdr_two;
  logic         blue_attacks;
  int           frame_pos;
  logic [7:0]   payload[3];

  assign pending_o = report_q.size();

  function automatic longint atan_deg(input int i);
    longint r;
    case (i)
      0: r = 2949120;  1: r = 1740967; 2: r = 919879;  3: r = 466945;
      4: r = 234379;   5: r = 117304;  6: r = 58666;   7: r = 29335;
      8: r = 14668;    9: r = 7334;    10: r = 3667;   11: r = 1833;
      12: r = 917;     13: r = 458;    14: r = 229;    15: r = 115;
      16: r = 57;      17: r = 29;     18: r = 14;     19: r = 7;
      20: r = 4;       21: r = 2;      22: r = 1;      default: r = 0;
    endcase
    return r;
  endfunction

  task automatic goal_bearing(input logic [7:0] rx, input logic [7:0] ry,
                              output logic signed [13:0] ang,
                              output logic [12:0] goal_dist);
    longint x, y, px, py, z, t, dx, dy, a;
    longint unsigned d;
    x = rx;
    y = ry;
    if (rx != AbsentByte) begin
      x = x - longint'(CentreOffset);
      y = y - longint'(CentreOffset);
    end
    if (x == 0 && y == 0) begin
      ang = 14'sd1440;
      goal_dist = '0;
      return;
    end
    px = x * 65536;
    py = y * 65536;
    z = 0;
    if (px < 0) begin
      t = px;
      if (py >= 0) begin
        px = py;
        py = -t;
        z = 90 * 65536;
      end else begin
        px = -py;
        py = t;
        z = -90 * 65536;
      end
    end
    for (int i = 0; i < int'(CordicSteps) && i < 24; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px = px + dx;
        py = py - dy;
        z = z + atan_deg(i);
      end else begin
        px = px - dx;
        py = py + dy;
        z = z - atan_deg(i);
      end
    end
    if (px < 0) px = 0;
    d = (longint'(px) * 64'd2608131496 + (64'd1 << 43)) >> 44;
    if (d > DistMax) d = DistMax;
    a = (90 * 65536 - z + 2048) >>> 12;
    if (a < AngleMin) a = AngleMin;
    if (a > AngleMax) a = AngleMax;
    ang = a[13:0];
    goal_dist = d[12:0];
  endtask

  task automatic take_byte(input logic [7:0] b);
    goal_report_t r;
    logic signed [13:0] ya, ba;
    logic [12:0] yd, bd;
    logic ys, bs;
    case (frame_pos)
      1: begin
        if (b == hdr_two) frame_pos = 2;
        else if (b == hdr_one) frame_pos = 1;
        else frame_pos = 0;
      end
      2, 3, 4: begin
        payload[frame_pos-2] = b;
        frame_pos = frame_pos + 1;
      end
      5: begin
        frame_pos = 0;
        goal_bearing(payload[0], payload[1], ya, yd);
        goal_bearing(payload[2], b, ba, bd);
        ys = (payload[1] != AbsentByte);
        bs = (b != AbsentByte);
        if (blue_attacks) begin
          r = '{ba, bd, ya, yd, bs, ys};
        end else begin
          r = '{ya, yd, ba, bd, ys, bs};
        end
        report_q.push_back(r);
      end
      default: frame_pos = (b == hdr_one) ? 1 : 0;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    goal_report_t e;
    if (!rst_ni) begin
      hdr_one <= '0;
      hdr_two <= '0;
      blue_attacks <= 1'b0;
      frame_pos = 0;
      report_q.delete();
      fail_count_o <= 0;
      reports_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartOne:   hdr_one <= cfg_data_i;
          CfgStartTwo:   hdr_two <= cfg_data_i;
          CfgAttackBlue: blue_attacks <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (push_i && !full_i) take_byte(link_byte_i);
      if (pop_i && !empty_i) begin
        reports_o <= reports_o + 1;
        if (report_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected goal report at %0t", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = report_q.pop_front();
          if (e.a_ang !== attack_angle_i || e.a_dist !== attack_distance_i ||
              e.d_ang !== defend_angle_i || e.d_dist !== defend_distance_i ||
              e.a_seen !== attack_seen_i || e.d_seen !== defend_seen_i) begin
            if (fail_count_o < 10)
              $display("mismatch: exp %0d %0d %0d %0d %0b %0b got %0d %0d %0d %0d %0b %0b",
                       e.a_ang, e.a_dist, e.d_ang, e.d_dist, e.a_seen, e.d_seen,
                       attack_angle_i, attack_distance_i, defend_angle_i,
                       defend_distance_i, attack_seen_i, defend_seen_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/camera_goal_packet_polar_tb.sv
// Testbench top for camera_goal_packet_polar: drives camera bytes, register
// settings and result pops; the checker module predicts and compares.
// Depends on cgpp_pkg, camera_goal_packet_polar and its checker.
`timescale 1ns / 1ps
module camera_goal_packet_polar_tb;
  import cgpp_pkg::*;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] link_byte = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [13:0] attack_angle, defend_angle;
  logic [12:0] attack_distance, defend_distance;
  logic attack_seen, defend_seen;
  int fail_count, pending, reports;
  int bytes_sent = 0;
  int phases_run = 0;
  int stall_cycles = 0;
  logic no_idle = 1'b0;
  logic [7:0] hdr_a, hdr_b;

  always #4 clk_i = ~clk_i;

  camera_goal_packet_polar uut (
    .clk_i, .rst_ni, .push, .full, .link_byte_i(link_byte),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .empty, .pop,
    .attack_angle_o(attack_angle), .attack_distance_o(attack_distance),
    .defend_angle_o(defend_angle), .defend_distance_o(defend_distance),
    .attack_seen_o(attack_seen), .defend_seen_o(defend_seen)
  );

  camera_goal_packet_polar_checker chk (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .link_byte_i(link_byte),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .empty_i(empty), .pop_i(pop),
    .attack_angle_i(attack_angle), .attack_distance_i(attack_distance),
    .defend_angle_i(defend_angle), .defend_distance_i(defend_distance),
    .attack_seen_i(attack_seen), .defend_seen_i(defend_seen),
    .fail_count_o(fail_count), .pending_o(pending), .reports_o(reports)
  );

  always @(negedge clk_i) pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("camera_goal_packet_polar_tb: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 6) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    link_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] yx, input logic [7:0] yy,
                             input logic [7:0] bx, input logic [7:0] by);
    send_byte(hdr_a);
    send_byte(hdr_b);
    send_byte(yx);
    send_byte(yy);
    send_byte(bx);
    send_byte(by);
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] one, input logic [7:0] two,
                          input logic blue);
    hdr_a = one;
    hdr_b = two;
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CfgStartOne;
    cfg_data <= one;
    @(negedge clk_i);
    cfg_idx <= CfgStartTwo;
    cfg_data <= two;
    @(negedge clk_i);
    cfg_idx <= CfgAttackBlue;
    cfg_data <= {7'($urandom_range(127)), blue};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  function automatic logic [7:0] coord();
    int k;
    k = $urandom_range(99);
    if (k < 8) return AbsentByte;
    if (k < 14) return CentreOffset;
    if (k < 18) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_run(input int count);
    int k;
    while (count > 0) begin
      k = $urandom_range(99);
      if (k < 85) begin
        send_packet(coord(), coord(), coord(), coord());
        count -= 6;
      end else if (k < 93) begin
        send_byte(hdr_a);
        send_byte(8'($urandom_range(255)));
        count -= 2;
      end else begin
        send_byte(8'($urandom_range(255)));
        count -= 1;
      end
    end
  endtask

  initial begin
    hdr_a = '0;
    hdr_b = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset header values: both zero
    send_packet(8'd60, 8'd60, 8'd255, 8'd255);
    send_packet(8'd0, 8'd0, 8'd255, 8'd0);
    drain();

    set_regs(8'hA5, 8'h5A, 1'b0);
    send_packet(8'd255, 8'd255, 8'd0, 8'd255);
    send_packet(8'd0, 8'd254, 8'd254, 8'd0);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'd61);
    send_byte(8'd60);
    send_byte(8'd59);
    send_byte(8'd120);
    send_byte(8'hA5);
    send_byte(8'h33);
    send_packet(8'd60, 8'd0, 8'd10, 8'd60);
    drain();

    set_regs(8'hFF, 8'hFF, 1'b1);
    send_packet(8'd60, 8'd200, 8'd255, 8'd60);
    no_idle = 1'b1;
    random_run(260);
    no_idle = 1'b0;
    drain();

    set_regs(8'h00, 8'hFF, 1'b0);
    random_run(280);
    drain();

    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    random_run(280);
    drain();

    set_regs(8'h55, 8'hAA, 1'b1);
    random_run(280);
    drain();

    set_regs(8'hAA, 8'h55, 1'b0);
    random_run(280);
    drain();

    $display("run: %0d bytes over %0d register settings, %0d goal reports checked",
             bytes_sent, phases_run, reports);
    if (fail_count == 0 && pending == 0) begin
      $display("camera_goal_packet_polar_tb: done, clean");
    end else begin
      $display("camera_goal_packet_polar_tb: done, errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/cgpp_pkg.sv
design/cgpp_framer.sv
design/cgpp_fifo.sv
design/cgpp_polar.sv
design/camera_goal_packet_polar.sv
design/cgpp_checker.sv
verif/camera_goal_packet_polar_checker.sv
verif/camera_goal_packet_polar_tb.sv
